### rtl/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder package
// Shared types, register and format codes, and constant divisions used by
// the palette stage, the pixel lanes and the output merge stage.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int DIM_W   = 15;
    localparam int COORD_W = 14;
    localparam int BCNT_W  = 14;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam logic [1:0] CFG_FORMAT_MODE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef logic [7:0] chan_t;

    // Index 0 is red, 1 is green, 2 is blue.
    typedef logic [2:0][7:0] color_t;

    typedef struct packed {
        chan_t  alpha;
        color_t color;
    } pixel_t;

    typedef struct packed {
        logic dxt1;
        logic dxt3;
        logic three;
    } mode_ctl_t;

    function automatic chan_t div3(input logic [9:0] v);
        logic [20:0] prod;
        prod = 21'(v) * 21'd683;
        return prod[18:11];
    endfunction

    function automatic chan_t div5(input logic [10:0] v);
        logic [21:0] prod;
        prod = 22'(v) * 22'd1639;
        return prod[20:13];
    endfunction

    function automatic chan_t div7(input logic [10:0] v);
        logic [22:0] prod;
        prod = 23'(v) * 23'd2341;
        return prod[21:14];
    endfunction

endpackage

### rtl/bcd_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC block decoder palette stage
// Builds the four-entry color palette and the eight-entry alpha table of one
// block and registers them together with the block's indices and position.
// ----------------------------------------------------------------------------
module bcd_palette #(
    parameter int BLK_W = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [63:0]                      alpha_word,
    input  logic [63:0]                      color_word,
    input  logic [1:0]                       format_mode,
    input  logic [BLK_W-1:0]                 blk_col,
    input  logic [BLK_W-1:0]                 blk_row,
    input  logic                             last_block,
    input  logic [bcd_pkg::DIM_W-1:0]        width_clamp,
    input  logic [bcd_pkg::DIM_W-1:0]        height_clamp,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bcd_pkg::color_t [3:0]            out_palette,
    output bcd_pkg::chan_t [7:0]             out_alpha_tab,
    output bcd_pkg::mode_ctl_t               out_mode,
    output logic [31:0]                      out_indices,
    output logic [63:0]                      out_alpha_word,
    output logic [BLK_W-1:0]                 out_col,
    output logic [BLK_W-1:0]                 out_row,
    output logic                             out_last,
    output logic [bcd_pkg::DIM_W-1:0]        out_width,
    output logic [bcd_pkg::DIM_W-1:0]        out_height
);

    logic                        valid_reg;
    logic                        valid_next;
    logic                        load;
    logic [15:0]                 c0;
    logic [15:0]                 c1;
    bcd_pkg::chan_t              a0;
    bcd_pkg::chan_t              a1;
    bcd_pkg::mode_ctl_t          mode;
    bcd_pkg::color_t [3:0]       pal;
    bcd_pkg::chan_t [7:0]        atab;

    bcd_pkg::color_t [3:0]       pal_reg;
    bcd_pkg::chan_t [7:0]        atab_reg;
    bcd_pkg::mode_ctl_t          mode_reg;
    logic [31:0]                 indices_reg;
    logic [63:0]                 alpha_word_reg;
    logic [BLK_W-1:0]            col_reg;
    logic [BLK_W-1:0]            row_reg;
    logic                        last_reg;
    logic [bcd_pkg::DIM_W-1:0]   width_reg;
    logic [bcd_pkg::DIM_W-1:0]   height_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        c0 = color_word[15:0];
        c1 = color_word[31:16];
        a0 = alpha_word[7:0];
        a1 = alpha_word[15:8];

        mode.dxt1  = (format_mode == bcd_pkg::FMT_DXT1);
        mode.dxt3  = (format_mode == bcd_pkg::FMT_DXT3);
        mode.three = mode.dxt1 && (c0 <= c1);

        pal[0] = {{c0[4:0], 3'b000}, {c0[10:5], 2'b00}, {c0[15:11], 3'b000}};
        pal[1] = {{c1[4:0], 3'b000}, {c1[10:5], 2'b00}, {c1[15:11], 3'b000}};
        for (int ch = 0; ch < 3; ch++) begin
            if (mode.three) begin
                pal[2][ch] = 8'((9'(pal[0][ch]) + 9'(pal[1][ch])) >> 1);
                pal[3][ch] = 8'd0;
            end else begin
                pal[2][ch] = bcd_pkg::div3(10'(pal[0][ch]) * 10'd2 + 10'(pal[1][ch]) + 10'd1);
                pal[3][ch] = bcd_pkg::div3(10'(pal[0][ch]) + 10'(pal[1][ch]) * 10'd2 + 10'd1);
            end
        end

        atab    = '0;
        atab[0] = a0;
        atab[1] = a1;
        if (a0 > a1) begin
            for (int i = 0; i < 6; i++) begin
                atab[i + 2] = bcd_pkg::div7(11'(a0) * 11'(6 - i) + 11'(a1) * 11'(i + 1)
                                            + 11'd3);
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                atab[i + 2] = bcd_pkg::div5(11'(a0) * 11'(4 - i) + 11'(a1) * 11'(i + 1)
                                            + 11'd2);
            end
            atab[6] = 8'd0;
            atab[7] = 8'd255;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pal_reg        <= pal;
            atab_reg       <= atab;
            mode_reg       <= mode;
            indices_reg    <= color_word[63:32];
            alpha_word_reg <= alpha_word;
            col_reg        <= blk_col;
            row_reg        <= blk_row;
            last_reg       <= last_block;
            width_reg      <= width_clamp;
            height_reg     <= height_clamp;
        end
    end

    assign out_valid      = valid_reg;
    assign out_palette    = pal_reg;
    assign out_alpha_tab  = atab_reg;
    assign out_mode       = mode_reg;
    assign out_indices    = indices_reg;
    assign out_alpha_word = alpha_word_reg;
    assign out_col        = col_reg;
    assign out_row        = row_reg;
    assign out_last       = last_reg;
    assign out_width      = width_reg;
    assign out_height     = height_reg;

endmodule

### rtl/bcd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC block decoder pixel lane
// Decodes one pixel of a block from the shared palette, the alpha table or its
// alpha nibble, and tells whether the pixel lies inside the image.
// ----------------------------------------------------------------------------
module bcd_lane #(
    parameter int BLK_W = 12
) (
    input  bcd_pkg::color_t [3:0]            palette,
    input  bcd_pkg::chan_t [7:0]             alpha_tab,
    input  bcd_pkg::mode_ctl_t               mode,
    input  logic [1:0]                       color_index,
    input  logic [2:0]                       alpha_code,
    input  logic [3:0]                       alpha_nibble,
    input  logic [BLK_W-1:0]                 blk_col,
    input  logic [BLK_W-1:0]                 blk_row,
    input  logic [bcd_pkg::DIM_W-1:0]        width,
    input  logic [bcd_pkg::DIM_W-1:0]        height,
    input  logic [1:0]                       lane_x,
    input  logic [1:0]                       lane_y,
    output bcd_pkg::pixel_t                  pixel,
    output logic                             visible
);

    always_comb begin
        pixel.color = palette[color_index];
        if (mode.dxt1) begin
            pixel.alpha = (mode.three && (color_index == 2'd3)) ? 8'd0 : 8'd255;
        end else if (mode.dxt3) begin
            pixel.alpha = {alpha_nibble, alpha_nibble};
        end else begin
            pixel.alpha = alpha_tab[alpha_code];
        end
        visible = (16'({blk_col, lane_x}) < 16'(width))
               && (16'({blk_row, lane_y}) < 16'(height));
    end

endmodule

### rtl/bcd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC block decoder merge stage
// Holds the sixteen decoded pixels of one block and sends the visible ones
// out in raster order via an output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module bcd_merge #(
    parameter int BLK_W = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bcd_pkg::pixel_t [15:0]           in_pixels,
    input  logic [15:0]                      in_mask,
    input  logic [BLK_W-1:0]                 in_col,
    input  logic [BLK_W-1:0]                 in_row,
    input  logic                             in_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bcd_pkg::COORD_W-1:0]      out_x,
    output logic [bcd_pkg::COORD_W-1:0]      out_y,
    output bcd_pkg::pixel_t                  out_pixel,
    output logic                             out_block_done,
    output logic                             out_image_done
);

    logic [15:0]                    mask_reg;
    logic [15:0]                    mask_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    bcd_pkg::pixel_t [15:0]         pix_reg;
    logic [BLK_W-1:0]               col_reg;
    logic [BLK_W-1:0]               row_reg;
    logic                           last_reg;
    logic [bcd_pkg::COORD_W-1:0]    x_reg;
    logic [bcd_pkg::COORD_W-1:0]    y_reg;
    bcd_pkg::pixel_t                pixel_reg;
    logic                           block_done_reg;
    logic                           image_done_reg;

    logic                           out_free;
    logic                           take;
    logic                           load;
    logic [15:0]                    pick;
    logic [15:0]                    rest;
    logic [3:0]                     sel;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        pick     = mask_reg & (~mask_reg + 16'd1);
        rest     = mask_reg & ~pick;
        take     = out_free && (mask_reg != 16'd0);
        sel      = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (pick[k]) begin
                sel = 4'(k);
            end
        end
        in_ready = (mask_reg == 16'd0) || (take && (rest == 16'd0));
        load     = in_valid && in_ready;

        mask_next = mask_reg;
        if (load) begin
            mask_next = in_mask;
        end else if (take) begin
            mask_next = rest;
        end

        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (out_free) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg  <= in_pixels;
            col_reg  <= in_col;
            row_reg  <= in_row;
            last_reg <= in_last;
        end
        if (take) begin
            x_reg          <= bcd_pkg::COORD_W'({col_reg, sel[1:0]});
            y_reg          <= bcd_pkg::COORD_W'({row_reg, sel[3:2]});
            pixel_reg      <= pix_reg[sel];
            block_done_reg <= (rest == 16'd0);
            image_done_reg <= (rest == 16'd0) && last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign out_x          = x_reg;
    assign out_y          = y_reg;
    assign out_pixel      = pixel_reg;
    assign out_block_done = block_done_reg;
    assign out_image_done = image_done_reg;

endmodule

### rtl/bc1_bc2_bc3_texture_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 texture block decoder
// Decodes compressed 4x4 blocks in raster block order into RGBA8 pixels with
// their image coordinates, skipping pixels outside the image.
//
//   Channel   Direction   Transfer content
//   s_*       in          one compressed block (alpha word, color word)
//   m_*       out         one pixel (coordinates, RGBA, block and image end)
//   cfg_*     in          one register write (index, data)
//
// A block yields one to sixteen pixels and the output sends one pixel per
// cycle while m_tready is high. A block passes the palette and merge block
// registers before its first pixel enters the output register. A new block
// is taken while the previous one is still being sent. Synchronous reset
// selects DXT1 at 1x1 pixels and block position zero and empties the
// pipeline. A stall on m_tready holds the output and backs up into s_tready.
// ----------------------------------------------------------------------------
module bc1_bc2_bc3_texture_block_decoder #(
    parameter int MAX_DIMENSION = 16384
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,    // alpha_word, color_word
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,    // pixel_x, pixel_y, red, green, blue, alpha
    output logic          m_tlast,
    output logic          m_tuser,    // image_done
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [14:0]   cfg_data
);

    localparam int DIM_MAX = (MAX_DIMENSION < 32767) ? MAX_DIMENSION : 32767;
    localparam int BLK_MAX = (DIM_MAX + 3) / 4;
    localparam int BLK_W   = (BLK_MAX > 1) ? $clog2(BLK_MAX) : 1;

    logic [1:0]                       format_mode_reg;
    logic [bcd_pkg::DIM_W-1:0]        image_width_reg;
    logic [bcd_pkg::DIM_W-1:0]        image_height_reg;
    logic [BLK_W-1:0]                 block_column_reg;
    logic [BLK_W-1:0]                 block_column_next;
    logic [BLK_W-1:0]                 block_row_reg;
    logic [BLK_W-1:0]                 block_row_next;

    logic [bcd_pkg::DIM_W-1:0]        width_clamp;
    logic [bcd_pkg::DIM_W-1:0]        height_clamp;
    logic [bcd_pkg::BCNT_W-1:0]       blocks_wide;
    logic [bcd_pkg::BCNT_W-1:0]       blocks_high;
    logic [BLK_W-1:0]                 col_eff;
    logic [BLK_W-1:0]                 row_eff;
    logic                             last_blk;
    logic                             s_accept;

    logic                             pal_valid;
    logic                             merge_ready;
    bcd_pkg::color_t [3:0]            pal_palette;
    bcd_pkg::chan_t [7:0]             pal_alpha_tab;
    bcd_pkg::mode_ctl_t               pal_mode;
    logic [31:0]                      pal_indices;
    logic [63:0]                      pal_alpha_word;
    logic [BLK_W-1:0]                 pal_col;
    logic [BLK_W-1:0]                 pal_row;
    logic                             pal_last;
    logic [bcd_pkg::DIM_W-1:0]        pal_width;
    logic [bcd_pkg::DIM_W-1:0]        pal_height;

    bcd_pkg::pixel_t [15:0]           lane_pixels;
    logic [15:0]                      lane_mask;

    logic [bcd_pkg::COORD_W-1:0]      out_x;
    logic [bcd_pkg::COORD_W-1:0]      out_y;
    bcd_pkg::pixel_t                  out_pixel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg  <= bcd_pkg::FMT_DXT1;
            image_width_reg  <= 15'd1;
            image_height_reg <= 15'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bcd_pkg::CFG_FORMAT_MODE: begin
                    format_mode_reg <= cfg_data[1:0];
                end
                bcd_pkg::CFG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_data;
                end
                bcd_pkg::CFG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            width_clamp = 15'd1;
        end else if (int'(image_width_reg) > DIM_MAX) begin
            width_clamp = 15'(DIM_MAX);
        end else begin
            width_clamp = image_width_reg;
        end
        if (image_height_reg == '0) begin
            height_clamp = 15'd1;
        end else if (int'(image_height_reg) > DIM_MAX) begin
            height_clamp = 15'(DIM_MAX);
        end else begin
            height_clamp = image_height_reg;
        end

        blocks_wide = 14'((16'(width_clamp) + 16'd3) >> 2);
        blocks_high = 14'((16'(height_clamp) + 16'd3) >> 2);
        col_eff = (14'(block_column_reg) >= blocks_wide) ? '0 : block_column_reg;
        row_eff = (14'(block_row_reg) >= blocks_high) ? '0 : block_row_reg;
        last_blk = (14'(col_eff) == blocks_wide - 14'd1)
                && (14'(row_eff) == blocks_high - 14'd1);

        s_accept = s_tvalid && s_tready;

        block_column_next = block_column_reg;
        block_row_next    = block_row_reg;
        if (s_accept) begin
            if (14'(col_eff) + 14'd1 >= blocks_wide) begin
                block_column_next = '0;
                if (14'(row_eff) + 14'd1 >= blocks_high) begin
                    block_row_next = '0;
                end else begin
                    block_row_next = row_eff + 1'b1;
                end
            end else begin
                block_column_next = col_eff + 1'b1;
                block_row_next    = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_column_reg <= '0;
            block_row_reg    <= '0;
        end else begin
            block_column_reg <= block_column_next;
            block_row_reg    <= block_row_next;
        end
    end

    bcd_palette #(
        .BLK_W (BLK_W)
    ) u_palette (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .alpha_word     (s_tdata[63:0]),
        .color_word     (s_tdata[127:64]),
        .format_mode    (format_mode_reg),
        .blk_col        (col_eff),
        .blk_row        (row_eff),
        .last_block     (last_blk),
        .width_clamp    (width_clamp),
        .height_clamp   (height_clamp),
        .out_valid      (pal_valid),
        .out_ready      (merge_ready),
        .out_palette    (pal_palette),
        .out_alpha_tab  (pal_alpha_tab),
        .out_mode       (pal_mode),
        .out_indices    (pal_indices),
        .out_alpha_word (pal_alpha_word),
        .out_col        (pal_col),
        .out_row        (pal_row),
        .out_last       (pal_last),
        .out_width      (pal_width),
        .out_height     (pal_height)
    );

    for (genvar k = 0; k < 16; k++) begin : g_lane
        bcd_lane #(
            .BLK_W (BLK_W)
        ) u_lane (
            .palette      (pal_palette),
            .alpha_tab    (pal_alpha_tab),
            .mode         (pal_mode),
            .color_index  (pal_indices[2*k +: 2]),
            .alpha_code   (pal_alpha_word[16 + 3*k +: 3]),
            .alpha_nibble (pal_alpha_word[4*k +: 4]),
            .blk_col      (pal_col),
            .blk_row      (pal_row),
            .width        (pal_width),
            .height       (pal_height),
            .lane_x       (2'(k % 4)),
            .lane_y       (2'(k / 4)),
            .pixel        (lane_pixels[k]),
            .visible      (lane_mask[k])
        );
    end

    bcd_merge #(
        .BLK_W (BLK_W)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (pal_valid),
        .in_ready       (merge_ready),
        .in_pixels      (lane_pixels),
        .in_mask        (lane_mask),
        .in_col         (pal_col),
        .in_row         (pal_row),
        .in_last        (pal_last),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_pixel      (out_pixel),
        .out_block_done (m_tlast),
        .out_image_done (m_tuser)
    );

    assign m_tdata = {4'b0000, out_pixel, out_y, out_x};

    // Every block handed to the merge stage has at least one visible pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pal_valid && merge_ready) |-> (lane_mask != 16'd0))
        else $error("block without visible pixel reached the merge stage");

    // The end of the image is always the end of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("image end flagged on a pixel that does not end its block");

    // After the last block of the image the position wraps to the origin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && last_blk) |=> (block_column_reg == '0 && block_row_reg == '0))
        else $error("block position did not wrap after the last block");

endmodule
